@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the edge-timing decoder.
// Standalone header; expects the including file to supply clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/med_pkg.sv @@
// Package for the Manchester edge-timing decoder: types, codes and reset values.
// No dependencies; imported by every module of the block except the checker.
package med_pkg;

  // Operation codes of an input word.
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Register indexes on the configuration port (word address bits).
  localparam int unsigned RegIdxW = 2;
  localparam logic [RegIdxW-1:0] REG_LONG_MIN  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_LONG_MAX  = 2'd1;
  localparam logic [RegIdxW-1:0] REG_SHORT_MIN = 2'd2;
  localparam logic [RegIdxW-1:0] REG_SHORT_MAX = 2'd3;

  localparam int unsigned AddrW = RegIdxW + 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned TimeW = 32;

  // Reset values of the gap windows, in timestamp ticks.
  localparam logic [TimeW-1:0] LONG_MIN_RST  = 32'd180000;
  localparam logic [TimeW-1:0] LONG_MAX_RST  = 32'd230000;
  localparam logic [TimeW-1:0] SHORT_MIN_RST = 32'd80000;
  localparam logic [TimeW-1:0] SHORT_MAX_RST = 32'd106000;

  // Gap windows handed from the register file to the decoder.
  typedef struct packed {
    logic [TimeW-1:0] long_min;
    logic [TimeW-1:0] long_max;
    logic [TimeW-1:0] short_min;
    logic [TimeW-1:0] short_max;
  } windows_t;

  // One input word as held in the input register.
  typedef struct packed {
    logic             op;
    logic             level;
    logic [TimeW-1:0] stamp;
  } item_t;

endpackage

@@ hw/rtl/med_cfg_regs.sv @@
// APB-style register file holding the four gap windows of the decoder.
// Depends on med_pkg.
module med_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [med_pkg::AddrW-1:0] paddr,
  input  logic [med_pkg::DataW-1:0] pwdata,
  output logic [med_pkg::DataW-1:0] prdata,
  output logic                   pready,
  output med_pkg::windows_t      windows_o
);
  import med_pkg::*;

  windows_t win_q, win_d;
  logic     wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  // Write decode.
  always_comb begin
    win_d = win_q;
    if (wr_en) begin
      unique case (idx)
        REG_LONG_MIN:  win_d.long_min  = pwdata;
        REG_LONG_MAX:  win_d.long_max  = pwdata;
        REG_SHORT_MIN: win_d.short_min = pwdata;
        REG_SHORT_MAX: win_d.short_max = pwdata;
        default:       win_d = win_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.long_min  <= LONG_MIN_RST;
      win_q.long_max  <= LONG_MAX_RST;
      win_q.short_min <= SHORT_MIN_RST;
      win_q.short_max <= SHORT_MAX_RST;
    end else begin
      win_q <= win_d;
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      REG_LONG_MIN:  prdata = win_q.long_min;
      REG_LONG_MAX:  prdata = win_q.long_max;
      REG_SHORT_MIN: prdata = win_q.short_min;
      REG_SHORT_MAX: prdata = win_q.short_max;
      default:       prdata = '0;
    endcase
  end

  assign windows_o = win_q;

endmodule

@@ hw/rtl/med_in_stage.sv @@
// Input register of the decoder: captures one edge word and holds it until taken.
// Depends on med_pkg.
module med_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic                edge_level_i,
  input  logic [med_pkg::TimeW-1:0] edge_time_i,
  input  logic                take_i,
  output logic                item_valid_o,
  output med_pkg::item_t      item_o
);
  import med_pkg::*;

  logic  valid_q, valid_d;
  logic  load;
  item_t item_q;

  // The register is free when empty or when its word moves on this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.op    <= op_i;
      item_q.level <= edge_level_i;
      item_q.stamp <= edge_time_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ hw/rtl/med_decode.sv @@
// Gap classification, pair counting and byte assembly, with the result register.
// Depends on med_pkg.
module med_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  med_pkg::item_t     item_i,
  input  med_pkg::windows_t  windows_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               bit_value_o,
  output logic               byte_done_o,
  output logic [7:0]         byte_value_o
);
  import med_pkg::*;

  logic             seen_q, seen_d;
  logic [TimeW-1:0] last_q, last_d;
  logic             pair_q, pair_d;
  logic [7:0]       shift_q, shift_d;
  logic [2:0]       count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             bit_q, done_q;
  logic [7:0]       value_q;

  logic [TimeW-1:0] gap;
  logic             in_long, in_short;
  logic             emit, done;
  logic [7:0]       shift_next, value;

  // The result register can load when empty or when its word is taken.
  assign take_o = item_valid_i && (!out_valid_q || !out_stall_i);

  // Gap since the previous edge, wrapping modulo 2^32; windows are inclusive.
  assign gap      = item_i.stamp - last_q;
  assign in_long  = (gap >= windows_i.long_min) && (gap <= windows_i.long_max);
  assign in_short = (gap >= windows_i.short_min) && (gap <= windows_i.short_max);
  assign shift_next = {shift_q[6:0], item_i.level};

  // State update for the word leaving the input register.
  always_comb begin
    seen_d  = seen_q;
    last_d  = last_q;
    pair_d  = pair_q;
    shift_d = shift_q;
    count_d = count_q;
    emit    = 1'b0;
    done    = 1'b0;
    value   = '0;
    if (take_o) begin
      if (item_i.op == OP_RESTART) begin
        seen_d  = 1'b0;
        last_d  = '0;
        pair_d  = 1'b0;
        shift_d = '0;
        count_d = '0;
      end else if (!seen_q) begin
        // The first edge only records its time.
        seen_d = 1'b1;
        last_d = item_i.stamp;
      end else begin
        last_d = item_i.stamp;
        if (in_long) begin
          emit = 1'b1;
        end else if (in_short) begin
          emit   = pair_q;
          pair_d = !pair_q;
        end
        if (emit) begin
          if (count_q == 3'd7) begin
            done    = 1'b1;
            value   = shift_next;
            shift_d = '0;
            count_d = '0;
          end else begin
            shift_d = shift_next;
            count_d = count_q + 3'd1;
          end
        end
      end
    end
  end

  // The result register holds its word while the far side stalls.
  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_q      <= '0;
      pair_q      <= 1'b0;
      shift_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      last_q      <= last_d;
      pair_q      <= pair_d;
      shift_q     <= shift_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      bit_q   <= item_i.level;
      done_q  <= done;
      value_q <= value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bit_value_o  = bit_q;
  assign byte_done_o  = done_q;
  assign byte_value_o = value_q;

endmodule

@@ hw/rtl/manchester_edge_timing_decoder_top.sv @@
// Manchester edge-timing decoder: one edge word per cycle while not stalled, decoded bits and bytes out.
// Top level; depends on med_pkg, med_cfg_regs, med_in_stage and med_decode.
//
// Each input word is either an edge (new line level and 32-bit timestamp) or a
// restart. The gap to the previous edge selects a full bit, half of a bit pair,
// or nothing; each decoded bit is shifted MSB first into a byte and the result
// word flags every eighth bit as completing a byte. The block accepts one word every
// clock cycle while in_stall_o is low; a word passes an input register, then a
// result register, before its bit is offered on the result ports; edges that decode
// no bit give no result word. Throughput is set by the single subtract-and-compare
// path between those two registers. The gap windows are written through the
// APB-style port; the user must write them only while no word is in flight, as the block does not enforce it.
module manchester_edge_timing_decoder_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [med_pkg::AddrW-1:0] paddr,
  input  logic [med_pkg::DataW-1:0] pwdata,
  output logic [med_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic                      edge_level_i,
  input  logic [med_pkg::TimeW-1:0] edge_time_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      bit_value_o,
  output logic                      byte_done_o,
  output logic [7:0]                byte_value_o
);
  import med_pkg::*;

  windows_t windows;
  item_t    item;
  logic     item_valid;
  logic     take;

  med_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .windows_o (windows)
  );

  med_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .edge_level_i (edge_level_i),
    .edge_time_i  (edge_time_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  med_decode u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .windows_i    (windows),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bit_value_o  (bit_value_o),
    .byte_done_o  (byte_done_o),
    .byte_value_o (byte_value_o)
  );

endmodule

@@ hw/rtl/med_checker.sv @@
// Port-level checks for the Manchester edge-timing decoder, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module med_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       bit_value_o,
  input logic       byte_done_o,
  input logic [7:0] byte_value_o
);

  // A held result word stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // The input side only stalls when the result register is blocked.
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A bit that does not finish a byte carries a zero byte field.
  `ASSERT_IMPLIES(a_byte_zero, clk_i, rst_ni, out_valid_o && !byte_done_o, byte_value_o == 8'd0)

  // The finishing bit is the least significant bit of the byte.
  `ASSERT_IMPLIES(a_byte_lsb, clk_i, rst_ni, out_valid_o && byte_done_o,
                  byte_value_o[0] == bit_value_o)

endmodule

bind manchester_edge_timing_decoder_top med_checker u_med_checker (.*);
